// ----- rtl/core/sth_pkg.sv -----
// ============================================================================
// sth_pkg - stick to hat quantizer shared definitions
// Register map, reset values, datapath widths and the CORDIC arctangent table.
// ============================================================================
package sth_pkg;

    localparam int AXIS_BITS_DEF  = 16;
    localparam int ANGLE_BITS_DEF = 16;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_SECTOR_COUNT = 2'd0;
    localparam logic [1:0] REG_ENGAGE       = 2'd1;
    localparam logic [1:0] REG_RELEASE      = 2'd2;

    localparam int SECT_W = 9;
    localparam int THR_W  = 15;
    localparam int POV_W  = 17;
    localparam int HELD_W = 8;

    localparam logic [SECT_W-1:0] SECTOR_RESET  = 9'd4;
    localparam logic [SECT_W-1:0] SECTOR_MAX    = 9'd256;
    localparam logic [THR_W-1:0]  ENGAGE_RESET  = 15'd26214;
    localparam logic [THR_W-1:0]  RELEASE_RESET = 15'd9830;
    localparam logic [POV_W-1:0]  POV_CENTERED  = '1;

    localparam int               CENTI_W           = 17;
    localparam logic [CENTI_W-1:0] CENTI_DOUBLE_TURN = 17'd72000;

    localparam int CORDIC_W   = 43;
    localparam int CORDIC_REF = 40;
    localparam int Z_W        = 32;
    localparam int ATAN_IDX_W = 5;

    localparam int DIV_NUM_W = 25;
    localparam int DIV_DEN_W = 10;
    localparam int DIV_Q_W   = 16;

    function automatic logic [Z_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
        logic [Z_W-1:0] r;
        case (idx)
            5'd0:    r = 32'h20000000;
            5'd1:    r = 32'h12E4051E;
            5'd2:    r = 32'h09FB385B;
            5'd3:    r = 32'h051111D4;
            5'd4:    r = 32'h028B0D43;
            5'd5:    r = 32'h0145D7E1;
            5'd6:    r = 32'h00A2F61E;
            5'd7:    r = 32'h00517C55;
            5'd8:    r = 32'h0028BE53;
            5'd9:    r = 32'h00145F2F;
            5'd10:   r = 32'h000A2F98;
            5'd11:   r = 32'h000517CC;
            5'd12:   r = 32'h00028BE6;
            5'd13:   r = 32'h000145F3;
            5'd14:   r = 32'h0000A2FA;
            5'd15:   r = 32'h0000517D;
            5'd16:   r = 32'h000028BE;
            5'd17:   r = 32'h0000145F;
            5'd18:   r = 32'h00000A30;
            5'd19:   r = 32'h00000518;
            5'd20:   r = 32'h0000028C;
            5'd21:   r = 32'h00000146;
            5'd22:   r = 32'h000000A3;
            5'd23:   r = 32'h00000051;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/sth_cordic.sv -----
// ============================================================================
// sth_cordic - iterative vectoring CORDIC
// Turn fraction of the stick direction, clockwise from up, one step a cycle.
// ============================================================================
module sth_cordic #(
    parameter int AXIS_BITS  = sth_pkg::AXIS_BITS_DEF,
    parameter int ANGLE_BITS = sth_pkg::ANGLE_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [AXIS_BITS-1:0]  x_in,
    input  logic signed [AXIS_BITS-1:0]  y_in,
    output logic                         done,
    output logic        [ANGLE_BITS-1:0] angle
);

    localparam int CW       = sth_pkg::CORDIC_W;
    localparam int ZW       = sth_pkg::Z_W;
    localparam int SCALE_SH = sth_pkg::CORDIC_REF - AXIS_BITS;
    localparam int SH       = ZW - ANGLE_BITS;
    localparam int IW       = $clog2(ANGLE_BITS);

    logic signed [CW-1:0] u_reg, v_reg;
    logic        [ZW-1:0] z_reg;
    logic        [IW-1:0] iter_reg;
    logic                 busy_reg, done_reg, zero_reg;

    logic signed [CW-1:0] xs, ys, u_sh, v_sh;
    logic                 v_pos;
    logic        [ZW-1:0] atan_val, z_round;

    assign xs       = CW'(x_in) <<< SCALE_SH;
    assign ys       = CW'(y_in) <<< SCALE_SH;
    assign u_sh     = u_reg >>> iter_reg;
    assign v_sh     = v_reg >>> iter_reg;
    assign v_pos    = !v_reg[CW-1] && (v_reg != '0);
    assign atan_val = sth_pkg::atan_turn(sth_pkg::ATAN_IDX_W'(iter_reg));
    assign z_round  = z_reg + (ZW'(1) << (SH - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            iter_reg <= '0;
            zero_reg <= (x_in == '0) && (y_in == '0);
            if (ys > 0) begin
                u_reg <= ys;
                v_reg <= -xs;
                z_reg <= {1'b1, {(ZW-1){1'b0}}};
            end else begin
                u_reg <= -ys;
                v_reg <= xs;
                z_reg <= '0;
            end
        end else if (busy_reg) begin
            if (v_pos) begin
                u_reg <= u_reg + v_sh;
                v_reg <= v_reg - u_sh;
                z_reg <= z_reg + atan_val;
            end else begin
                u_reg <= u_reg - v_sh;
                v_reg <= v_reg + u_sh;
                z_reg <= z_reg - atan_val;
            end
            if (iter_reg == IW'(ANGLE_BITS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                iter_reg <= iter_reg + IW'(1);
            end
        end
    end

    assign done  = done_reg;
    assign angle = zero_reg ? '0 : z_round[ZW-1:SH];

endmodule

// ----- rtl/core/sth_div.sv -----
// ============================================================================
// sth_div - restoring divider
// Sector centre to centidegrees, one quotient bit a cycle.
// ============================================================================
module sth_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [sth_pkg::DIV_NUM_W-1:0] num,
    input  logic [sth_pkg::DIV_DEN_W-1:0] den,
    output logic                          done,
    output logic [sth_pkg::DIV_Q_W-1:0]   quot
);

    localparam int NW = sth_pkg::DIV_NUM_W;
    localparam int DW = sth_pkg::DIV_DEN_W;
    localparam int QW = sth_pkg::DIV_Q_W;
    localparam int CNTW = $clog2(QW);

    logic [DW-1:0]   rem_reg, den_reg;
    logic [QW-1:0]   sh_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg, done_reg;

    logic [DW:0]     trial, diff;
    logic            fits;

    assign trial = {rem_reg, sh_reg[QW-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            den_reg  <= den;
            rem_reg  <= DW'(num[NW-1:QW]);
            sh_reg   <= num[QW-1:0];
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DW-1:0] : trial[DW-1:0];
            sh_reg  <= {sh_reg[QW-2:0], fits};
            if (cnt_reg == CNTW'(QW - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end else begin
                cnt_reg <= cnt_reg + CNTW'(1);
            end
        end
    end

    assign done = done_reg;
    assign quot = sh_reg;

endmodule

// ----- rtl/core/stick_to_hat_quantizer.sv -----
// ============================================================================
// stick_to_hat_quantizer - joystick sample to hat switch direction
// Hysteresis on radius and angle, nearest of N sectors, centidegree output.
//
//   channel  | ports                     | moves
//   ---------+---------------------------+-----------------------------------
//   s_       | s_valid/s_ready           | one x,y sample per request
//   m_       | m_valid/m_ready           | pov_angle, zero or one per sample
//   apb      | psel/penable/pwrite/paddr | sector_count, engage, release
//
// A repeated sample goes straight back to idle from the check state; the CORDIC
// steps one iteration a cycle and the divider one quotient bit a cycle, around a
// single shared multiplier.
// Reset is synchronous.
// A result waits in the output register; the next sample is taken meanwhile.
// ============================================================================
module stick_to_hat_quantizer #(
    parameter int AXIS_BITS  = sth_pkg::AXIS_BITS_DEF,
    parameter int ANGLE_BITS = sth_pkg::ANGLE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [AXIS_BITS-1:0]         s_x_value,
    input  logic signed [AXIS_BITS-1:0]         s_y_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [sth_pkg::POV_W-1:0]    m_pov_angle,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic        [sth_pkg::PADDR_W-1:0]  paddr,
    input  logic        [sth_pkg::PDATA_W-1:0]  pwdata,
    output logic        [sth_pkg::PDATA_W-1:0]  prdata,
    output logic                                pready
);

    localparam int SW     = sth_pkg::SECT_W;
    localparam int HW     = sth_pkg::HELD_W;
    localparam int PVW    = sth_pkg::POV_W;
    localparam int MUL_W0 = (AXIS_BITS > ANGLE_BITS) ? AXIS_BITS : ANGLE_BITS;
    localparam int MUL_W  = (MUL_W0 > sth_pkg::CENTI_W) ? MUL_W0 : sth_pkg::CENTI_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int R2W    = 2 * AXIS_BITS;
    localparam int PW     = ANGLE_BITS + SW;
    localparam int TW     = PW + 2;
    localparam int KW     = PW + 1 - ANGLE_BITS;
    localparam int NW     = sth_pkg::DIV_NUM_W;
    localparam int DW     = sth_pkg::DIV_DEN_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_X,
        ST_MUL_Y,
        ST_MUL_T,
        ST_RADIUS,
        ST_ANGLE,
        ST_DECIDE,
        ST_MUL_K,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    logic signed [AXIS_BITS-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [AXIS_BITS-1:0] prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    logic        [AXIS_BITS-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic                        released_reg, released_next;
    logic        [HW-1:0]        held_reg, held_next;
    logic        [SW-1:0]        n_reg, n_next;
    logic        [R2W-1:0]       r2_reg, r2_next;
    logic        [PROD_W-1:0]    prod_reg, prod_next;
    logic        [PVW-1:0]       res_reg, res_next;
    logic                        m_valid_reg, m_valid_next;
    logic        [PVW-1:0]       m_pov_reg, m_pov_next;
    logic        [SW-1:0]        sector_reg, sector_next;
    logic        [sth_pkg::THR_W-1:0] engage_reg, engage_next, release_reg, release_next;

    logic [MUL_W-1:0]      mul_a, mul_b;
    logic                  same, below, skip, cfg_wr;
    logic [1:0]            reg_idx;
    logic                  cordic_start, cordic_done, div_start, div_done;
    logic [ANGLE_BITS-1:0] angle;
    logic [sth_pkg::DIV_Q_W-1:0] quot;
    logic [NW-1:0]         div_num;
    logic [DW-1:0]         div_den;

    logic [PW-1:0] p;
    logic [TW-1:0] p2, p4, unit_t, hi0_t, up_t, dn_t;
    logic [9:0]    n2m1, hk4;
    logic [PW:0]   ksum;
    logic [KW-1:0] k_raw;
    logic [HW-1:0] k_sel;

    sth_cordic #(
        .AXIS_BITS  (AXIS_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .x_in    (x_reg),
        .y_in    (y_reg),
        .done    (cordic_done),
        .angle   (angle)
    );

    sth_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (quot)
    );

    assign same         = (x_reg == prev_x_reg) && (y_reg == prev_y_reg);
    assign cordic_start = (state_reg == ST_CHECK) && !same;
    assign div_start    = (state_reg == ST_DIV_GO);
    assign div_num      = prod_reg[NW-1:0] + NW'(n_reg);
    assign div_den      = {n_reg, 1'b0};
    assign below        = PROD_W'(r2_reg) < prod_reg;

    assign p      = prod_reg[PW-1:0];
    assign p2     = TW'(p) << 1;
    assign p4     = TW'(p) << 2;
    assign unit_t = TW'(1) << ANGLE_BITS;
    assign n2m1   = {n_reg, 1'b0} - 10'd1;
    assign hi0_t  = TW'(n2m1) << ANGLE_BITS;
    assign hk4    = {held_reg, 2'b00};
    assign up_t   = TW'(hk4 + 10'd3) << ANGLE_BITS;
    assign dn_t   = TW'(hk4 - 10'd3) << ANGLE_BITS;
    assign ksum   = (PW + 1)'(p) + ((PW + 1)'(1) << (ANGLE_BITS - 1));
    assign k_raw  = ksum[PW:ANGLE_BITS];
    assign k_sel  = (k_raw >= KW'(n_reg)) ? '0 : k_raw[HW-1:0];

    always_comb begin
        if (released_reg) begin
            skip = 1'b0;
        end else if (held_reg == '0) begin
            skip = (p2 <= unit_t) || (p2 >= hi0_t);
        end else begin
            skip = (p4 <= up_t) && (p4 >= dn_t);
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MUL_X: begin
                mul_a = MUL_W'(ax_reg);
                mul_b = MUL_W'(ax_reg);
            end
            ST_MUL_Y: begin
                mul_a = MUL_W'(ay_reg);
                mul_b = MUL_W'(ay_reg);
            end
            ST_MUL_T: begin
                mul_a = MUL_W'(released_reg ? engage_reg : release_reg);
                mul_b = MUL_W'(released_reg ? engage_reg : release_reg);
            end
            ST_ANGLE: begin
                mul_a = MUL_W'(angle);
                mul_b = MUL_W'(n_reg);
            end
            ST_MUL_K: begin
                mul_a = MUL_W'(held_reg);
                mul_b = MUL_W'(sth_pkg::CENTI_DOUBLE_TURN);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_comb begin
        sector_next  = sector_reg;
        engage_next  = engage_reg;
        release_next = release_reg;
        if (cfg_wr) begin
            case (reg_idx)
                sth_pkg::REG_SECTOR_COUNT: sector_next  = pwdata[SW-1:0];
                sth_pkg::REG_ENGAGE:       engage_next  = pwdata[sth_pkg::THR_W-1:0];
                sth_pkg::REG_RELEASE:      release_next = pwdata[sth_pkg::THR_W-1:0];
                default: begin
                    sector_next = sector_reg;
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            sth_pkg::REG_SECTOR_COUNT: prdata = sth_pkg::PDATA_W'(sector_reg);
            sth_pkg::REG_ENGAGE:       prdata = sth_pkg::PDATA_W'(engage_reg);
            sth_pkg::REG_RELEASE:      prdata = sth_pkg::PDATA_W'(release_reg);
            default:                   prdata = '0;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        prev_x_next   = prev_x_reg;
        prev_y_next   = prev_y_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        released_next = released_reg;
        held_next     = held_reg;
        n_next        = n_reg;
        r2_next       = r2_reg;
        res_next      = res_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_pov_next    = m_pov_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    x_next     = s_x_value;
                    y_next     = s_y_value;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (same) begin
                    state_next = ST_IDLE;
                end else begin
                    prev_x_next = x_reg;
                    prev_y_next = y_reg;
                    ax_next     = x_reg[AXIS_BITS-1] ? $unsigned(-x_reg) : $unsigned(x_reg);
                    ay_next     = y_reg[AXIS_BITS-1] ? $unsigned(-y_reg) : $unsigned(y_reg);
                    if (sector_reg == '0) begin
                        n_next = SW'(1);
                    end else if (sector_reg > sth_pkg::SECTOR_MAX) begin
                        n_next = sth_pkg::SECTOR_MAX;
                    end else begin
                        n_next = sector_reg;
                    end
                    state_next = ST_MUL_X;
                end
            end
            ST_MUL_X: begin
                state_next = ST_MUL_Y;
            end
            ST_MUL_Y: begin
                r2_next    = prod_reg[R2W-1:0];
                state_next = ST_MUL_T;
            end
            ST_MUL_T: begin
                r2_next    = r2_reg + prod_reg[R2W-1:0];
                state_next = ST_RADIUS;
            end
            ST_RADIUS: begin
                if (below) begin
                    if (released_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        released_next = 1'b1;
                        held_next     = '0;
                        res_next      = sth_pkg::POV_CENTERED;
                        state_next    = ST_OUT;
                    end
                end else begin
                    state_next = ST_ANGLE;
                end
            end
            ST_ANGLE: begin
                if (cordic_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (skip) begin
                    state_next = ST_IDLE;
                end else begin
                    released_next = 1'b0;
                    held_next     = k_sel;
                    state_next    = ST_MUL_K;
                end
            end
            ST_MUL_K: begin
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    res_next   = PVW'(quot);
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_pov_next   = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            prev_x_reg   <= '0;
            prev_y_reg   <= {1'b1, {(AXIS_BITS-1){1'b0}}};
            released_reg <= 1'b0;
            held_reg     <= '0;
            m_valid_reg  <= 1'b0;
            sector_reg   <= sth_pkg::SECTOR_RESET;
            engage_reg   <= sth_pkg::ENGAGE_RESET;
            release_reg  <= sth_pkg::RELEASE_RESET;
        end else begin
            state_reg    <= state_next;
            prev_x_reg   <= prev_x_next;
            prev_y_reg   <= prev_y_next;
            released_reg <= released_next;
            held_reg     <= held_next;
            m_valid_reg  <= m_valid_next;
            sector_reg   <= sector_next;
            engage_reg   <= engage_next;
            release_reg  <= release_next;
        end
        x_reg     <= x_next;
        y_reg     <= y_next;
        ax_reg    <= ax_next;
        ay_reg    <= ay_next;
        n_reg     <= n_next;
        r2_reg    <= r2_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
        m_pov_reg <= m_pov_next;
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_pov_angle = m_pov_reg;
    assign pready      = 1'b1;

endmodule

// ----- rtl/core/sth_checker.sv -----
// ============================================================================
// sth_checker - port level checks for the stick to hat quantizer
// Input hold, output hold, result range, one request at a time, ready after
// reset.
// ============================================================================
module sth_checker #(
    parameter int AXIS_BITS = sth_pkg::AXIS_BITS_DEF
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_valid,
    input logic                               s_ready,
    input logic signed [AXIS_BITS-1:0]        s_x_value,
    input logic signed [AXIS_BITS-1:0]        s_y_value,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [sth_pkg::POV_W-1:0]   m_pov_angle
);

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_x_value) && $stable(s_y_value))
        else $error("sample changed while waiting");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pov_angle))
        else $error("result changed while stalled");

    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_pov_angle == sth_pkg::POV_CENTERED) ||
                    ($unsigned(m_pov_angle) < 17'd36000))
        else $error("result outside hat range");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready held through a sample");

    a_reset_ready: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("not idle after reset");

endmodule

bind stick_to_hat_quantizer sth_checker #(.AXIS_BITS(AXIS_BITS)) u_sth_checker (.*);
